### hdl/rcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_pkg
// shared widths and stage-to-stage types for the rectangle/circle overlap test
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int COORD_W = 24;               // signed Q15.8 coordinate
  localparam int RAD_W   = COORD_W - 1;      // unsigned Q15.8 radius
  localparam int DIFF_W  = COORD_W + 1;      // difference of two coordinates
  localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
  localparam int SUM_W   = PROD_W + 1;       // signed dot / cross product
  localparam int MAG_W   = PROD_W;           // squared length, |cross|
  localparam int R2_W    = 2 * RAD_W;        // radius squared
  localparam int HALF_M  = MAG_W / 2;        // split point of magnitudes
  localparam int HALF_R  = R2_W / 2;         // split point of radius squared
  localparam int WIDE_W  = 2 * MAG_W;        // products of squares
  localparam int NCORN   = 4;

  // per-stage load enables
  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } rcc_ld_t;

  // sums of products, one set per corner / edge
  typedef struct packed {
    logic [NCORN-1:0][MAG_W-1:0] lw;    // |center - corner|^2
    logic [NCORN-1:0][MAG_W-1:0] a;     // |edge|^2
    logic [NCORN-1:0][SUM_W-1:0] proj;  // edge . (center - start)
    logic [NCORN-1:0][SUM_W-1:0] cr;    // edge x (center - start)
    logic [R2_W-1:0]             r2;
  } rcc_geom_t;

  // decisions after the narrow compares
  typedef struct packed {
    logic                        early;  // corner inside circle or center inside
    logic [NCORN-1:0]            mid;    // projection falls strictly inside edge
    logic [NCORN-1:0][MAG_W-1:0] crm;
    logic [NCORN-1:0][MAG_W-1:0] a;
    logic [R2_W-1:0]             r2;
  } rcc_cls_t;

endpackage

### hdl/rect_circle_collision_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_circle_collision_top
// rectangle / circle overlap test, one transaction per cycle unless stalled, seven stages
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_stall  | corner0..3 x/y, center_x/y, radius
//   out     | out_valid / out_stall| hit
//
// a new transaction can enter every cycle unless the pipe is stalled;
// out_valid rises when it has moved from stage 6 into the output register.
// the depth is set by the 50x50 cross-squared and 46x50 r^2*len^2 products,
// which are split into 25x25 and 23x25 partial products over two stages.
// no state is carried between transactions.
// rst (synchronous) clears only the stage valid bits; payload is not reset.
// each stage loads when it is empty or the stage after it loads, so bubbles
// collapse and a stall at the output holds every full stage in place.
// ----------------------------------------------------------------------------
module rect_circle_collision_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner0_x,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner0_y,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner1_x,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner1_y,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner2_x,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner2_y,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner3_x,
  input  logic signed [rcc_pkg::COORD_W-1:0]  corner3_y,
  input  logic signed [rcc_pkg::COORD_W-1:0]  center_x,
  input  logic signed [rcc_pkg::COORD_W-1:0]  center_y,
  input  logic        [rcc_pkg::RAD_W-1:0]    radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit
);

  // corner arrays in cyclic order
  logic signed [rcc_pkg::COORD_W-1:0] px [rcc_pkg::NCORN];
  logic signed [rcc_pkg::COORD_W-1:0] py [rcc_pkg::NCORN];

  rcc_pkg::rcc_ld_t   ld;
  rcc_pkg::rcc_geom_t geom;
  rcc_pkg::rcc_cls_t  cls;

  // valid bits of stages 1..6, stage 7 is the output register
  logic [6:1]                vld;
  logic                      early5, early6;
  logic [rcc_pkg::NCORN-1:0] edge_hit;

  assign px[0] = corner0_x;
  assign py[0] = corner0_y;
  assign px[1] = corner1_x;
  assign py[1] = corner1_y;
  assign px[2] = corner2_x;
  assign py[2] = corner2_y;
  assign px[3] = corner3_x;
  assign py[3] = corner3_y;

  // load enables ripple back from the output
  always_comb begin
    ld.s7 = !out_valid || !out_stall;
    ld.s6 = !vld[6] || ld.s7;
    ld.s5 = !vld[5] || ld.s6;
    ld.s4 = !vld[4] || ld.s5;
    ld.s3 = !vld[3] || ld.s4;
    ld.s2 = !vld[2] || ld.s3;
    ld.s1 = !vld[1] || ld.s2;
  end

  assign in_stall = !ld.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ld.s1) vld[1]    <= in_valid;
      if (ld.s2) vld[2]    <= vld[1];
      if (ld.s3) vld[3]    <= vld[2];
      if (ld.s4) vld[4]    <= vld[3];
      if (ld.s5) vld[5]    <= vld[4];
      if (ld.s6) vld[6]    <= vld[5];
      if (ld.s7) out_valid <= vld[6];
    end
  end

  // stages 1-3: differences, products, sums
  rcc_front u_front (
    .clk  (clk),
    .ld   (ld),
    .px   (px),
    .py   (py),
    .cx   (center_x),
    .cy   (center_y),
    .rad  (radius),
    .geom (geom)
  );

  // stage 4: corner / inside / projection range decisions
  rcc_classify u_classify (
    .clk  (clk),
    .ld   (ld),
    .geom (geom),
    .cls  (cls)
  );

  // stages 5-6: wide distance test, one unit per edge
  for (genvar i = 0; i < rcc_pkg::NCORN; i++) begin : g_edge
    rcc_edge u_edge (
      .clk      (clk),
      .ld       (ld),
      .mid      (cls.mid[i]),
      .crm      (cls.crm[i]),
      .a        (cls.a[i]),
      .r2       (cls.r2),
      .edge_hit (edge_hit[i])
    );
  end

  // early hit rides along with the edge units, then the final or
  always_ff @(posedge clk) begin
    if (ld.s5) early5 <= cls.early;
    if (ld.s6) early6 <= early5;
    if (ld.s7) hit    <= early6 || (|edge_hit);
  end

  // an accepted transaction lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted transaction missing from stage 1");

  // input can only be held back by a full stage 1
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[1])
    else $error("input stalled with empty stage 1");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && (vld == '0)))
    else $error("pipeline not empty after reset");

endmodule

### hdl/rcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_front
// stages 1 to 3: coordinate differences, 25x25 products, sums of products
// ----------------------------------------------------------------------------
module rcc_front (
  input  logic                                   clk,
  input  rcc_pkg::rcc_ld_t                       ld,
  input  logic signed [rcc_pkg::COORD_W-1:0]     px [rcc_pkg::NCORN],
  input  logic signed [rcc_pkg::COORD_W-1:0]     py [rcc_pkg::NCORN],
  input  logic signed [rcc_pkg::COORD_W-1:0]     cx,
  input  logic signed [rcc_pkg::COORD_W-1:0]     cy,
  input  logic        [rcc_pkg::RAD_W-1:0]       rad,
  output rcc_pkg::rcc_geom_t                     geom
);

  // stage 1
  logic signed [rcc_pkg::DIFF_W-1:0] wx [rcc_pkg::NCORN];
  logic signed [rcc_pkg::DIFF_W-1:0] wy [rcc_pkg::NCORN];
  logic signed [rcc_pkg::DIFF_W-1:0] dx [rcc_pkg::NCORN];
  logic signed [rcc_pkg::DIFF_W-1:0] dy [rcc_pkg::NCORN];
  logic        [rcc_pkg::RAD_W-1:0]  r1;

  // stage 2
  logic signed [rcc_pkg::PROD_W-1:0] wx2 [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] wy2 [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] dx2 [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] dy2 [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] pxw [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] pyw [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] cxy [rcc_pkg::NCORN];
  logic signed [rcc_pkg::PROD_W-1:0] cyx [rcc_pkg::NCORN];
  logic        [rcc_pkg::R2_W-1:0]   r2;

  for (genvar i = 0; i < rcc_pkg::NCORN; i++) begin : g_corner
    localparam int J = (i + 1) % rcc_pkg::NCORN;

    always_ff @(posedge clk) begin
      if (ld.s1) begin
        wx[i] <= rcc_pkg::DIFF_W'(cx) - rcc_pkg::DIFF_W'(px[i]);
        wy[i] <= rcc_pkg::DIFF_W'(cy) - rcc_pkg::DIFF_W'(py[i]);
        dx[i] <= rcc_pkg::DIFF_W'(px[J]) - rcc_pkg::DIFF_W'(px[i]);
        dy[i] <= rcc_pkg::DIFF_W'(py[J]) - rcc_pkg::DIFF_W'(py[i]);
      end
      if (ld.s2) begin
        wx2[i] <= rcc_pkg::PROD_W'(wx[i]) * rcc_pkg::PROD_W'(wx[i]);
        wy2[i] <= rcc_pkg::PROD_W'(wy[i]) * rcc_pkg::PROD_W'(wy[i]);
        dx2[i] <= rcc_pkg::PROD_W'(dx[i]) * rcc_pkg::PROD_W'(dx[i]);
        dy2[i] <= rcc_pkg::PROD_W'(dy[i]) * rcc_pkg::PROD_W'(dy[i]);
        pxw[i] <= rcc_pkg::PROD_W'(dx[i]) * rcc_pkg::PROD_W'(wx[i]);
        pyw[i] <= rcc_pkg::PROD_W'(dy[i]) * rcc_pkg::PROD_W'(wy[i]);
        cxy[i] <= rcc_pkg::PROD_W'(dx[i]) * rcc_pkg::PROD_W'(wy[i]);
        cyx[i] <= rcc_pkg::PROD_W'(dy[i]) * rcc_pkg::PROD_W'(wx[i]);
      end
      if (ld.s3) begin
        geom.lw[i]   <= $unsigned(wx2[i]) + $unsigned(wy2[i]);
        geom.a[i]    <= $unsigned(dx2[i]) + $unsigned(dy2[i]);
        geom.proj[i] <= rcc_pkg::SUM_W'(pxw[i]) + rcc_pkg::SUM_W'(pyw[i]);
        geom.cr[i]   <= rcc_pkg::SUM_W'(cxy[i]) - rcc_pkg::SUM_W'(cyx[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      r1 <= rad;
    end
    if (ld.s2) begin
      r2 <= rcc_pkg::R2_W'(r1) * rcc_pkg::R2_W'(r1);
    end
    if (ld.s3) begin
      geom.r2 <= r2;
    end
  end

endmodule

### hdl/rcc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_classify
// stage 4: corner, center-inside and projection-range decisions
// ----------------------------------------------------------------------------
module rcc_classify (
  input  logic               clk,
  input  rcc_pkg::rcc_ld_t   ld,
  input  rcc_pkg::rcc_geom_t geom,
  output rcc_pkg::rcc_cls_t  cls
);

  logic [rcc_pkg::NCORN-1:0]                    corner;
  logic [rcc_pkg::NCORN-1:0]                    proj_pos;
  logic [rcc_pkg::NCORN-1:0]                    cr_pos;
  logic [rcc_pkg::NCORN-1:0]                    mid_next;
  logic [rcc_pkg::NCORN-1:0][rcc_pkg::SUM_W-1:0] cr_neg;
  logic [rcc_pkg::NCORN-1:0][rcc_pkg::MAG_W-1:0] crm_next;
  logic                                         ctr_in;

  always_comb begin
    for (int i = 0; i < rcc_pkg::NCORN; i++) begin
      corner[i]   = geom.lw[i] < rcc_pkg::MAG_W'(geom.r2);
      proj_pos[i] = !geom.proj[i][rcc_pkg::SUM_W-1] && (geom.proj[i] != '0);
      cr_pos[i]   = !geom.cr[i][rcc_pkg::SUM_W-1] && (geom.cr[i] != '0);
      // strictly between start and end of the edge
      mid_next[i] = proj_pos[i] && (geom.proj[i][rcc_pkg::MAG_W-1:0] < geom.a[i]);
      cr_neg[i]   = rcc_pkg::SUM_W'(0) - geom.cr[i];
      crm_next[i] = geom.cr[i][rcc_pkg::SUM_W-1] ? cr_neg[i][rcc_pkg::MAG_W-1:0]
                                                 : geom.cr[i][rcc_pkg::MAG_W-1:0];
    end
    // center on the inner side at corner 0 and corner 2
    ctr_in = cr_pos[0] && !geom.proj[0][rcc_pkg::SUM_W-1] &&
             cr_pos[2] && !geom.proj[2][rcc_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      cls.early <= (|corner) || ctr_in;
      cls.mid   <= mid_next;
      cls.crm   <= crm_next;
      cls.a     <= geom.a;
      cls.r2    <= geom.r2;
    end
  end

endmodule

### hdl/rcc_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcc_edge
// stages 5 and 6: cross^2 against r^2 * |edge|^2 for one edge, split products
// ----------------------------------------------------------------------------
module rcc_edge (
  input  logic                       clk,
  input  rcc_pkg::rcc_ld_t           ld,
  input  logic                       mid,
  input  logic [rcc_pkg::MAG_W-1:0]  crm,
  input  logic [rcc_pkg::MAG_W-1:0]  a,
  input  logic [rcc_pkg::R2_W-1:0]   r2,
  output logic                       edge_hit
);

  localparam int HM = rcc_pkg::HALF_M;
  localparam int HR = rcc_pkg::HALF_R;
  localparam int MW = rcc_pkg::MAG_W;
  localparam int RW = rcc_pkg::R2_W;
  localparam int WW = rcc_pkg::WIDE_W;

  // stage 5 partial products
  logic [MW-1:0] ll, lh, hh;
  logic [MW-1:0] pll, plh, phl, phh;
  logic          mid5;

  // stage 6 full products
  logic [WW-1:0] sq, ra;
  logic          mid6;

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      ll   <= MW'(crm[HM-1:0])  * MW'(crm[HM-1:0]);
      lh   <= MW'(crm[HM-1:0])  * MW'(crm[MW-1:HM]);
      hh   <= MW'(crm[MW-1:HM]) * MW'(crm[MW-1:HM]);
      pll  <= MW'(r2[HR-1:0])   * MW'(a[HM-1:0]);
      plh  <= MW'(r2[HR-1:0])   * MW'(a[MW-1:HM]);
      phl  <= MW'(r2[RW-1:HR])  * MW'(a[HM-1:0]);
      phh  <= MW'(r2[RW-1:HR])  * MW'(a[MW-1:HM]);
      mid5 <= mid;
    end
    if (ld.s6) begin
      sq   <= (WW'(hh) << (2 * HM)) + (WW'(lh) << (HM + 1)) + WW'(ll);
      ra   <= (WW'(phh) << (HM + HR)) + (WW'(plh) << HM) + (WW'(phl) << HR) + WW'(pll);
      mid6 <= mid5;
    end
  end

  assign edge_hit = mid6 && (sq < ra);

  // projection strictly inside the edge needs a nonzero edge length
  a_mid_len: assert property (@(posedge clk) mid |-> (a != '0))
    else $error("mid-edge case on a zero-length edge");

endmodule

### tb/tb_rect_circle_collision_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_circle_collision_top
// self-checking regression for the rectangle / circle overlap pipeline
//
// every accepted transaction is run through an exact integer model of the
// three overlap tests (corner in circle, center in rectangle, edge distance)
// and the predicted hit flag is queued. a monitor compares each accepted
// result with the oldest prediction. directed cases cover the corner, edge
// and extreme-value cases, then shaped and raw random transactions run with
// random idling on both sides, a long stall-free stretch, an output hold-off
// that backs the pipe up into the input, and full drains between phases.
// ----------------------------------------------------------------------------
module tb_rect_circle_collision_top;

  localparam int LATENCY      = 7;
  localparam int DRAIN_CYCLES = LATENCY + 8;
  localparam int IDLE_PCT     = 36;
  localparam int C_MIN        = -8388608;
  localparam int C_MAX        = 8388607;
  localparam int R_MAX        = 8388607;
  localparam int MAX_PRINTS   = 100;

  // one input transaction, field by field
  typedef struct packed {
    logic [rcc_pkg::NCORN-1:0][rcc_pkg::COORD_W-1:0] px;
    logic [rcc_pkg::NCORN-1:0][rcc_pkg::COORD_W-1:0] py;
    logic [rcc_pkg::COORD_W-1:0]                     cx;
    logic [rcc_pkg::COORD_W-1:0]                     cy;
    logic [rcc_pkg::RAD_W-1:0]                       r;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [rcc_pkg::COORD_W-1:0] corner0_x = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner0_y = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner1_x = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner1_y = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner2_x = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner2_y = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner3_x = '0;
  logic signed [rcc_pkg::COORD_W-1:0] corner3_y = '0;
  logic signed [rcc_pkg::COORD_W-1:0] center_x  = '0;
  logic signed [rcc_pkg::COORD_W-1:0] center_y  = '0;
  logic        [rcc_pkg::RAD_W-1:0]   radius    = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               hit;

  // predicted hit flags, oldest first
  bit expected_hits[$];
  int mismatches  = 0;
  int results_got = 0;

  // no-idle stretch on both sides while set
  bit calm = 1'b0;
  // output hold-off request: a new sequence number asks for hold_len cycles
  int hold_seq = 0;
  int hold_len = 0;

  rect_circle_collision_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .corner0_x (corner0_x),
    .corner0_y (corner0_y),
    .corner1_x (corner1_x),
    .corner1_y (corner1_y),
    .corner2_x (corner2_x),
    .corner2_y (corner2_y),
    .corner3_x (corner3_x),
    .corner3_y (corner3_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // overlap predictor, exact integer arithmetic on the Q15.8 values
  // differences fit in 25 bits and their products in 50, so longint holds
  // everything except the cross^2 against r^2 * len^2 compare
  // --------------------------------------------------------------------------
  function automatic longint sq_len(longint dx, longint dy);
    return dx * dx + dy * dy;
  endfunction

  // center on the inner side of edge a->b and not behind a
  function automatic bit center_ahead(longint ax, longint ay, longint bx, longint by,
                                      longint qx, longint qy);
    longint ux, uy, vx, vy;
    ux = bx - ax;
    uy = by - ay;
    vx = qx - ax;
    vy = qy - ay;
    return (ux * vy - uy * vx > 0) && (ux * vx + uy * vy >= 0);
  endfunction

  function automatic bit overlap_of(query_t q);
    longint      x[rcc_pkg::NCORN];
    longint      y[rcc_pkg::NCORN];
    longint      qx, qy, r2, dx, dy, wx, wy, len_sq, proj, cr;
    logic [127:0] cr_w, r2_w, len_w;
    bit          h;
    int          j;
    h = 1'b0;
    for (int i = 0; i < rcc_pkg::NCORN; i++) begin
      x[i] = longint'($signed(q.px[i]));
      y[i] = longint'($signed(q.py[i]));
    end
    qx = longint'($signed(q.cx));
    qy = longint'($signed(q.cy));
    r2 = longint'(q.r) * longint'(q.r);

    // a corner strictly inside the circle
    for (int i = 0; i < rcc_pkg::NCORN; i++)
      if (sq_len(x[i] - qx, y[i] - qy) < r2) h = 1'b1;

    // center inside, judged from corner 0 and corner 2
    if (center_ahead(x[0], y[0], x[1], y[1], qx, qy) &&
        center_ahead(x[2], y[2], x[3], y[3], qx, qy))
      h = 1'b1;

    // distance to each edge with the projection clamped to the segment
    for (int i = 0; i < rcc_pkg::NCORN; i++) begin
      j      = (i + 1) % rcc_pkg::NCORN;
      dx     = x[j] - x[i];
      dy     = y[j] - y[i];
      wx     = qx - x[i];
      wy     = qy - y[i];
      len_sq = sq_len(dx, dy);
      proj   = dx * wx + dy * wy;
      if (proj <= 0) begin
        // before the start, and every zero-length edge
        if (sq_len(wx, wy) < r2) h = 1'b1;
      end else if (proj >= len_sq) begin
        if (sq_len(qx - x[j], qy - y[j]) < r2) h = 1'b1;
      end else begin
        cr = dx * wy - dy * wx;
        if (cr < 0) cr = -cr;
        cr_w  = 128'(cr);
        r2_w  = 128'(r2);
        len_w = 128'(len_sq);
        if (cr_w * cr_w < r2_w * len_w) h = 1'b1;
      end
    end
    return h;
  endfunction

  // --------------------------------------------------------------------------
  // transaction builders
  // --------------------------------------------------------------------------
  function automatic query_t quad(int ax, int ay, int bx, int by, int cx, int cy,
                                  int dx, int dy, int ox, int oy, int r);
    query_t q;
    q.px[0] = rcc_pkg::COORD_W'(ax);
    q.py[0] = rcc_pkg::COORD_W'(ay);
    q.px[1] = rcc_pkg::COORD_W'(bx);
    q.py[1] = rcc_pkg::COORD_W'(by);
    q.px[2] = rcc_pkg::COORD_W'(cx);
    q.py[2] = rcc_pkg::COORD_W'(cy);
    q.px[3] = rcc_pkg::COORD_W'(dx);
    q.py[3] = rcc_pkg::COORD_W'(dy);
    q.cx    = rcc_pkg::COORD_W'(ox);
    q.cy    = rcc_pkg::COORD_W'(oy);
    q.r     = rcc_pkg::RAD_W'(r);
    return q;
  endfunction

  // axis-aligned, counter-clockwise from the low corner
  function automatic query_t box(int xlo, int ylo, int xhi, int yhi,
                                 int ox, int oy, int r);
    return quad(xlo, ylo, xhi, ylo, xhi, yhi, xlo, yhi, ox, oy, r);
  endfunction

  function automatic int rand_signed(int bits);
    return int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 5))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return rand_signed(8);
    endcase
  endfunction

  // rectangle of random size, tilt and winding with the circle placed around it
  function automatic query_t shaped_query();
    int bits, ox, oy, ux, uy, vx, vy, a, b, cx, cy, r, t;
    bits = $urandom_range(3, 20);
    if ($urandom_range(0, 3) == 0) begin
      ox = $urandom;
      oy = $urandom;
    end else begin
      ox = rand_signed(bits + 1);
      oy = rand_signed(bits + 1);
    end
    ux = rand_signed(bits);
    uy = rand_signed(bits);
    if ($urandom_range(0, 9) < 4) uy = 0;
    else if ($urandom_range(0, 9) == 0) ux = 0;
    vx = -uy;
    vy = ux;
    case ($urandom_range(0, 2))
      1: begin
        vx = vx * 2;
        vy = vy * 2;
      end
      2: begin
        vx = vx >>> 1;
        vy = vy >>> 1;
      end
      default: ;
    endcase
    // reversed winding
    if ($urandom_range(0, 4) == 0) begin
      t = ux; ux = vx; vx = t;
      t = uy; uy = vy; vy = t;
    end
    a  = int'($urandom_range(0, 12)) - 3;
    b  = int'($urandom_range(0, 12)) - 3;
    cx = ox + (a * ux + b * vx) / 8 + rand_signed(bits - 2);
    cy = oy + (a * uy + b * vy) / 8 + rand_signed(bits - 2);
    r  = int'($urandom_range(0, 1 << bits));
    if ($urandom_range(0, 9) == 0) r = 0;
    return quad(ox, oy, ox + ux, oy + uy, ox + ux + vx, oy + uy + vy,
                ox + vx, oy + vy, cx, cy, r);
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------
  // one transaction on the input channel; valid is left high on return
  task automatic send_query(input query_t q);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(5, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    corner0_x <= q.px[0];
    corner0_y <= q.py[0];
    corner1_x <= q.px[1];
    corner1_y <= q.py[1];
    corner2_x <= q.px[2];
    corner2_y <= q.py[2];
    corner3_x <= q.px[3];
    corner3_y <= q.py[3];
    center_x  <= q.cx;
    center_y  <= q.cy;
    radius    <= q.r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_hits.push_back(overlap_of(q));
  endtask

  // sender stops until every predicted result is back, then lets the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls, a calm stretch, or a counted hold-off
  initial begin : receiver
    int seen;
    int left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = hold_len;
      end
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else if (calm || rst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_got));
      end else begin
        if (hit !== expected_hits[0])
          report_mismatch($sformatf("result %0d: hit %b, expected %b",
                                    results_got, hit, expected_hits[0]));
        void'(expected_hits.pop_front());
      end
      results_got++;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_corner_cases();
    // corner inside the circle
    send_query(box(0, 0, 1024, 1024, 1100, 1100, 200));
    // zero radius with the center outside and inside, then radius 1 inside
    send_query(box(0, 0, 1024, 1024, 1100, 1100, 0));
    send_query(box(0, 0, 1024, 1024, 512, 512, 0));
    send_query(box(0, 0, 1024, 1024, 512, 512, 1));
    // clockwise winding around the center
    send_query(quad(0, 0, 0, 1024, 1024, 1024, 1024, 0, 512, 512, 16));
    // corner exactly on the circle
    send_query(box(0, 0, 256, 256, 1024, 1280, 1280));
    // center on an edge, center on a corner
    send_query(box(0, 0, 1024, 1024, 512, 0, 1));
    send_query(box(0, 0, 1024, 1024, 0, 0, 0));
    drain();
  endtask

  task automatic test_edge_cases();
    // projection inside the edge, below and exactly at the distance
    send_query(box(0, 0, 4096, 256, 2048, 400, 200));
    send_query(box(0, 0, 4096, 256, 2048, 400, 144));
    // projection before the start and past the end
    send_query(box(0, 0, 4096, 256, -120, -90, 160));
    send_query(box(0, 0, 4096, 256, 4200, -80, 100));
    // zero-length edge, all corners on one point
    send_query(quad(500, 500, 500, 500, 900, 500, 900, 900, 700, 480, 30));
    send_query(quad(300, 300, 300, 300, 300, 300, 300, 300, 310, 300, 11));
    // not a rectangle
    send_query(quad(0, 0, 2000, 300, 1500, 1800, -200, 900, 900, 900, 5));
    drain();
  endtask

  task automatic test_extremes();
    send_query(quad(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                    C_MAX, C_MAX, R_MAX));
    send_query(quad(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                    C_MIN, C_MIN, 0));
    send_query(quad(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                    C_MAX, C_MAX, R_MAX));
    send_query(quad(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                    C_MIN, C_MIN, R_MAX));
    // full-span rectangle
    send_query(box(C_MIN, C_MIN, C_MAX, C_MAX, 0, 0, 0));
    send_query(box(C_MIN, C_MIN, C_MAX, C_MAX, -1, -1, 1));
    send_query(quad(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX,
                    C_MAX, C_MIN, R_MAX));
    drain();
  endtask

  // output held off while the input keeps offering, so the pipe fills
  task automatic test_backpressure_fill();
    calm     <= 1'b1;
    hold_len <= 80;
    hold_seq <= hold_seq + 1;
    repeat (40) send_query(shaped_query());
    calm <= 1'b0;
    drain();
  endtask

  task automatic test_random_shapes(input int count);
    for (int i = 0; i < count; i++) begin
      // stall-free stretch in the middle of the run
      if (i == count / 3) calm <= 1'b1;
      if (i == count / 3 + 250) calm <= 1'b0;
      send_query(shaped_query());
    end
    drain();
  endtask

  // raw full-range fields and mixes of extreme values
  task automatic test_random_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_query(quad($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom));
      else
        send_query(quad(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                        pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                        pick_extreme(), pick_extreme(),
                        ($urandom_range(0, 1) == 0) ? R_MAX : int'($urandom_range(0, 15))));
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_corner_cases();
    test_edge_cases();
    test_extremes();
    test_backpressure_fill();
    test_random_shapes(1400);
    test_random_noise(390);

    if (expected_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_hits.size()));
    if (mismatches == 0) begin
      $display("rect_circle_collision_top regression: pass");
    end else begin
      $display("rect_circle_collision_top regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("rect_circle_collision_top regression: fail");
    $finish;
  end

endmodule

### sim.f
hdl/rcc_pkg.sv
hdl/rcc_front.sv
hdl/rcc_classify.sv
hdl/rcc_edge.sv
hdl/rect_circle_collision_top.sv
tb/tb_rect_circle_collision_top.sv
